/* rtl/column_min_max_scaler_assert.svh */
// assertion macros for the column min-max scaler
`ifndef COLUMN_MIN_MAX_SCALER_ASSERT_SVH
`define COLUMN_MIN_MAX_SCALER_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define CMMS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define CMMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/cmms_pkg.sv */
// shared constants, codes and types of the column min-max scaler
`default_nettype none
package cmms_pkg;

   localparam int MAX_COLUMNS = 64;
   localparam int CIDX_W      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int DATA_W      = 32;
   localparam int COL_W       = 6;
   localparam int OP_W        = 3;
   localparam int ST_W        = 2;
   localparam int ALU_W       = DATA_W + 2;
   localparam int QUO_W       = DATA_W + 1;
   localparam int FRAC_W      = 16;
   localparam int DIV_STEPS   = QUO_W;
   localparam int CNT_W       = $clog2(DIV_STEPS + 1);

   localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [OP_W-1:0] {
      OP_TRACK = 3'd0,
      OP_SCALE = 3'd1,
      OP_CLEAR = 3'd2,
      OP_LOAD  = 3'd3,
      OP_READ  = 3'd4
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK         = 2'd0,
      ST_ZERO_RANGE = 2'd1,
      ST_SATURATED  = 2'd2,
      ST_NO_STATS   = 2'd3
   } status_type;

   typedef struct packed {
      logic [ALU_W-1:0] diff;
      logic             neg;
      logic             zero;
   } alu_res_type;

   typedef struct packed {
      logic              we;
      logic [CIDX_W-1:0] waddr;
      logic [CIDX_W-1:0] raddr;
      logic [DATA_W-1:0] wmin;
      logic [DATA_W-1:0] wmax;
   } ram_ctl_type;

   typedef struct packed {
      logic [DATA_W-1:0] scaled;
      logic [DATA_W-1:0] cmin;
      logic [DATA_W-1:0] cmax;
      status_type        status;
   } result_type;

endpackage
`default_nettype wire

/* rtl/column_min_max_scaler.sv */
// top level of the per-column min-max scaler
//
//  channel | direction | tdata (low bit up)                      | tuser
//  req_    | in        | column, sample, given_max, 2 zero bits  | operation
//  rsp_    | out       | scaled, col_min_out, col_max_out        | status
//
// one word is taken while req_tready is high; req_tready stays low until that
// word's result has been handed to the output register
// a scale: setup, 33 quotient bits on the shared subtractor, sign fix-up, handover,
// but a zero range or too wide a quotient stops it early; track widens and writes back
// or stores a first sample; load, read, clear, spare codes, unseen columns just hand over
// reset: synchronous, clears the sequencer, the column flags and rsp_tvalid
// a stalled rsp_ side holds the result and the next word may still be taken;
// that word then waits in its last step until the output register is free
`default_nettype none
module column_min_max_scaler (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // column[5:0], sample[37:6], given_max[69:38], zero
   input  wire logic [2:0]  req_tuser,   // operation[2:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [95:0] rsp_tdata,   // scaled[31:0], col_min_out[63:32], col_max_out[95:64]
   output logic      [1:0]  rsp_tuser    // status[1:0]
);
   import cmms_pkg::*;

`include "column_min_max_scaler_assert.svh"

   // input word unpacking
   logic [COL_W-1:0]  req_col;
   logic [DATA_W-1:0] req_sample;
   logic [DATA_W-1:0] req_gmax;

   assign req_col    = req_tdata[COL_W-1:0];
   assign req_sample = req_tdata[COL_W +: DATA_W];
   assign req_gmax   = req_tdata[COL_W + DATA_W +: DATA_W];

   ram_ctl_type       ram_ctl;
   logic [DATA_W-1:0] rd_min;
   logic [DATA_W-1:0] rd_max;
   logic [ALU_W-1:0]  alu_a;
   logic [ALU_W-1:0]  alu_b;
   alu_res_type       alu_res;
   logic              out_free;
   logic              res_valid;
   result_type        res;

   // output register
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   result_type        rsp_ff, rsp_in;

   // column minimum and maximum stores, shared address
   cmms_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_COLUMNS)
   ) u_min_ram (
      .clock (clock),
      .we    (ram_ctl.we),
      .waddr (ram_ctl.waddr),
      .wdata (ram_ctl.wmin),
      .raddr (ram_ctl.raddr),
      .rdata (rd_min)
   );

   cmms_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_COLUMNS)
   ) u_max_ram (
      .clock (clock),
      .we    (ram_ctl.we),
      .waddr (ram_ctl.waddr),
      .wdata (ram_ctl.wmax),
      .raddr (ram_ctl.raddr),
      .rdata (rd_max)
   );

   // the one subtractor every arithmetic step goes through
   cmms_alu u_alu (
      .opa (alu_a),
      .opb (alu_b),
      .res (alu_res)
   );

   cmms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_op     (req_tuser),
      .req_col    (req_col),
      .req_sample (req_sample),
      .req_gmax   (req_gmax),
      .ram_ctl    (ram_ctl),
      .rd_min     (rd_min),
      .rd_max     (rd_max),
      .alu_a      (alu_a),
      .alu_b      (alu_b),
      .alu_res    (alu_res),
      .out_free   (out_free),
      .res_valid  (res_valid),
      .res        (res)
   );

   // register is free when empty or being drained this cycle
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_in        = rsp_ff;
      if (res_valid && out_free) begin
         rsp_tvalid_in = 1'b1;
         rsp_in        = res;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_ff.cmax, rsp_ff.cmin, rsp_ff.scaled};
   assign rsp_tuser  = rsp_ff.status;

   // one word at a time: the sequencer is busy right after taking a word
   `CMMS_ASSERT_NEXT(a_busy_after_take, clock, reset, req_tvalid && req_tready, !req_tready,
      "input taken while the sequencer was still busy")

   // a zero range never carries a scaled value
   `CMMS_ASSERT_SAME(a_zero_range_clean, clock, reset,
      rsp_tvalid && (status_type'(rsp_tuser) == ST_ZERO_RANGE), rsp_tdata[31:0] == '0,
      "zero range result with nonzero scaled value")

   // a column without statistics reports all value fields as zero
   `CMMS_ASSERT_SAME(a_no_stats_clean, clock, reset,
      rsp_tvalid && (status_type'(rsp_tuser) == ST_NO_STATS), rsp_tdata == '0,
      "missing statistics result with nonzero value fields")

   // the sequencer only offers a result while it is not taking input
   `CMMS_ASSERT_SAME(a_done_not_ready, clock, reset, res_valid, !req_tready,
      "result offered while input side is open")
endmodule
`default_nettype wire

/* rtl/cmms_ram.sv */
// generic single write port ram with registered read
`default_nettype none
module cmms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                  clock,
   input  wire logic                                  we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                      wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                      rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

/* rtl/cmms_alu.sv */
// shared subtractor used for compares, ranges, negation and divide steps
`default_nettype none
module cmms_alu (
   input  wire logic [cmms_pkg::ALU_W-1:0] opa,
   input  wire logic [cmms_pkg::ALU_W-1:0] opb,
   output cmms_pkg::alu_res_type           res
);
   import cmms_pkg::*;

   logic [ALU_W-1:0] diff;

   assign diff     = opa - opb;
   assign res.diff = diff;
   assign res.neg  = diff[ALU_W-1];
   assign res.zero = (diff == '0);
endmodule
`default_nettype wire

/* rtl/cmms_ctrl.sv */
// sequencer, column flags and divider registers around the shared subtractor
`default_nettype none
module cmms_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [cmms_pkg::OP_W-1:0]   req_op,
   input  wire logic [cmms_pkg::COL_W-1:0]  req_col,
   input  wire logic [cmms_pkg::DATA_W-1:0] req_sample,
   input  wire logic [cmms_pkg::DATA_W-1:0] req_gmax,
   output cmms_pkg::ram_ctl_type            ram_ctl,
   input  wire logic [cmms_pkg::DATA_W-1:0] rd_min,
   input  wire logic [cmms_pkg::DATA_W-1:0] rd_max,
   output logic      [cmms_pkg::ALU_W-1:0]  alu_a,
   output logic      [cmms_pkg::ALU_W-1:0]  alu_b,
   input  wire cmms_pkg::alu_res_type       alu_res,
   input  wire logic                        out_free,
   output logic                             res_valid,
   output cmms_pkg::result_type             res
);
   import cmms_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_DIFF    = 9'b000000010,
      S_SPAN    = 9'b000000100,
      S_ABS_NUM = 9'b000001000,
      S_ABS_DEN = 9'b000010000,
      S_PRE     = 9'b000100000,
      S_DIV     = 9'b001000000,
      S_SIGN    = 9'b010000000,
      S_DONE    = 9'b100000000
   } state_type;

   state_type         state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [DATA_W-1:0] smp_ff, smp_in;
   logic [DATA_W-1:0] gmax_ff, gmax_in;
   logic [DATA_W-1:0] mn_ff, mn_in;
   logic [DATA_W-1:0] mx_ff, mx_in;
   logic [ALU_W-1:0]  diff_ff, diff_in;
   logic [ALU_W-1:0]  span_ff, span_in;
   logic [QUO_W-1:0]  den_ff, den_in;
   logic [QUO_W-1:0]  dvd_ff, dvd_in;
   logic [QUO_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [MAX_COLUMNS-1:0] seen_ff, seen_in;
   result_type        res_ff, res_in;

   logic              col_ok;
   logic [CIDX_W-1:0] col_idx;
   logic              seen_hit;
   logic [ALU_W-1:0]  trial;
   logic [QUO_W-1:0]  abs_val;
   logic              pos_ovf;
   logic              neg_ovf;

   assign col_ok   = (32'(col_ff) < 32'(MAX_COLUMNS));
   assign col_idx  = CIDX_W'(col_ff);
   assign seen_hit = col_ok && seen_ff[col_idx];
   assign trial    = {1'b0, rem_ff} << 1 | ALU_W'(dvd_ff[QUO_W-1]);
   assign abs_val  = alu_res.diff[QUO_W-1:0];
   assign pos_ovf  = quo_ff[QUO_W-1] | quo_ff[QUO_W-2];
   assign neg_ovf  = quo_ff[QUO_W-1] | (quo_ff[QUO_W-2] & (|quo_ff[QUO_W-3:0]));

   // operand selection for the shared subtractor
   always_comb begin
      alu_a = '0;
      alu_b = '0;
      case (state_ff)
         S_DIFF: begin
            alu_a = {{2{smp_ff[DATA_W-1]}}, smp_ff};
            alu_b = {{2{rd_min[DATA_W-1]}}, rd_min};
         end
         S_SPAN: begin
            alu_a = {{2{mx_ff[DATA_W-1]}}, mx_ff};
            if (op_type'(op_ff) == OP_TRACK) begin
               alu_b = {{2{smp_ff[DATA_W-1]}}, smp_ff};
            end else begin
               alu_b = {{2{mn_ff[DATA_W-1]}}, mn_ff};
            end
         end
         S_ABS_NUM: alu_b = diff_ff;
         S_ABS_DEN: alu_b = span_ff;
         S_PRE: begin
            alu_a = {1'b0, rem_ff};
            alu_b = {1'b0, den_ff};
         end
         S_DIV: begin
            alu_a = trial;
            alu_b = {1'b0, den_ff};
         end
         S_SIGN: alu_b = {1'b0, quo_ff};
         default: begin
            alu_a = '0;
            alu_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      col_in   = col_ff;
      smp_in   = smp_ff;
      gmax_in  = gmax_ff;
      mn_in    = mn_ff;
      mx_in    = mx_ff;
      diff_in  = diff_ff;
      span_in  = span_ff;
      den_in   = den_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      seen_in  = seen_ff;
      res_in   = res_ff;
      ram_ctl.we    = 1'b0;
      ram_ctl.waddr = col_idx;
      ram_ctl.raddr = (state_ff == S_IDLE) ? CIDX_W'(req_col) : col_idx;
      ram_ctl.wmin  = smp_ff;
      ram_ctl.wmax  = smp_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req_op;
               col_in   = req_col;
               smp_in   = req_sample;
               gmax_in  = req_gmax;
               state_in = S_DIFF;
            end
         end

         // ram read data is here; dispatch on the operation
         S_DIFF: begin
            res_in.scaled = '0;
            res_in.cmin   = '0;
            res_in.cmax   = '0;
            res_in.status = ST_OK;
            state_in      = S_DONE;
            case (op_type'(op_ff))
               OP_TRACK: begin
                  if (!col_ok) begin
                     res_in.status = ST_NO_STATS;
                  end else if (!seen_ff[col_idx]) begin
                     ram_ctl.we       = 1'b1;
                     seen_in[col_idx] = 1'b1;
                     res_in.cmin      = smp_ff;
                     res_in.cmax      = smp_ff;
                  end else begin
                     mn_in    = rd_min;
                     mx_in    = rd_max;
                     diff_in  = alu_res.diff;
                     state_in = S_SPAN;
                  end
               end
               OP_SCALE: begin
                  if (!seen_hit) begin
                     res_in.status = ST_NO_STATS;
                  end else begin
                     mn_in       = rd_min;
                     mx_in       = rd_max;
                     diff_in     = alu_res.diff;
                     res_in.cmin = rd_min;
                     res_in.cmax = rd_max;
                     state_in    = S_SPAN;
                  end
               end
               OP_CLEAR: seen_in = '0;
               OP_LOAD: begin
                  if (!col_ok) begin
                     res_in.status = ST_NO_STATS;
                  end else begin
                     ram_ctl.we       = 1'b1;
                     ram_ctl.wmax     = gmax_ff;
                     seen_in[col_idx] = 1'b1;
                     res_in.cmin      = smp_ff;
                     res_in.cmax      = gmax_ff;
                  end
               end
               OP_READ: begin
                  if (!seen_hit) begin
                     res_in.status = ST_NO_STATS;
                  end else begin
                     res_in.cmin = rd_min;
                     res_in.cmax = rd_max;
                  end
               end
               default: res_in.status = ST_OK;
            endcase
         end

         // track: widen and write back; scale: range and zero check
         S_SPAN: begin
            if (op_type'(op_ff) == OP_TRACK) begin
               ram_ctl.we   = 1'b1;
               ram_ctl.wmin = diff_ff[ALU_W-1] ? smp_ff : mn_ff;
               ram_ctl.wmax = alu_res.neg ? smp_ff : mx_ff;
               res_in.cmin  = ram_ctl.wmin;
               res_in.cmax  = ram_ctl.wmax;
               state_in     = S_DONE;
            end else if (alu_res.zero) begin
               res_in.status = ST_ZERO_RANGE;
               state_in      = S_DONE;
            end else begin
               span_in  = alu_res.diff;
               state_in = S_ABS_NUM;
            end
         end

         // magnitude of the difference, shifted left by the fraction width
         S_ABS_NUM: begin
            if (diff_ff[ALU_W-1]) begin
               rem_in = QUO_W'(abs_val >> (FRAC_W + 1));
               dvd_in = {abs_val[FRAC_W:0], {FRAC_W{1'b0}}};
            end else begin
               rem_in = QUO_W'(diff_ff[QUO_W-1:0] >> (FRAC_W + 1));
               dvd_in = {diff_ff[FRAC_W:0], {FRAC_W{1'b0}}};
            end
            state_in = S_ABS_DEN;
         end

         S_ABS_DEN: begin
            den_in   = span_ff[ALU_W-1] ? abs_val : span_ff[QUO_W-1:0];
            neg_in   = diff_ff[ALU_W-1] ^ span_ff[ALU_W-1];
            state_in = S_PRE;
         end

         // upper dividend bits not below the divisor: quotient too wide
         S_PRE: begin
            if (!alu_res.neg) begin
               res_in.scaled = neg_ff ? SAT_MIN : SAT_MAX;
               res_in.status = ST_SATURATED;
               state_in      = S_DONE;
            end else begin
               quo_in   = '0;
               cnt_in   = CNT_W'(DIV_STEPS);
               state_in = S_DIV;
            end
         end

         // restoring divide, one quotient bit a cycle
         S_DIV: begin
            dvd_in = dvd_ff << 1;
            if (alu_res.neg) begin
               rem_in = trial[QUO_W-1:0];
               quo_in = {quo_ff[QUO_W-2:0], 1'b0};
            end else begin
               rem_in = alu_res.diff[QUO_W-1:0];
               quo_in = {quo_ff[QUO_W-2:0], 1'b1};
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = S_SIGN;
            end
         end

         S_SIGN: begin
            if (!neg_ff && pos_ovf) begin
               res_in.scaled = SAT_MAX;
               res_in.status = ST_SATURATED;
            end else if (neg_ff && neg_ovf) begin
               res_in.scaled = SAT_MIN;
               res_in.status = ST_SATURATED;
            end else if (neg_ff) begin
               res_in.scaled = alu_res.diff[DATA_W-1:0];
            end else begin
               res_in.scaled = quo_ff[DATA_W-1:0];
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            res_valid = 1'b1;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         seen_ff  <= '0;
      end else begin
         state_ff <= state_in;
         seen_ff  <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      col_ff  <= col_in;
      smp_ff  <= smp_in;
      gmax_ff <= gmax_in;
      mn_ff   <= mn_in;
      mx_ff   <= mx_in;
      diff_ff <= diff_in;
      span_ff <= span_in;
      den_ff  <= den_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
   end

   assign res = res_ff;
endmodule
`default_nettype wire

/* tb/sv/column_min_max_scaler_test.sv */
// self-checking testbench of the column min-max scaler: scoreboard class and driving top module

class scaler_scoreboard;
   localparam int REPORT_CAP = 80;

   logic signed [cmms_pkg::DATA_W-1:0] col_low  [cmms_pkg::MAX_COLUMNS];
   logic signed [cmms_pkg::DATA_W-1:0] col_high [cmms_pkg::MAX_COLUMNS];
   bit                                 col_seen [cmms_pkg::MAX_COLUMNS];
   cmms_pkg::result_type               awaited_results[$];
   int                                 errors;
   int                                 reported;
   int                                 words_checked;
   int                                 op_count[8];
   int                                 status_count[4];

   function new();
      foreach (col_seen[i]) col_seen[i] = 1'b0;
      errors        = 0;
      reported      = 0;
      words_checked = 0;
      foreach (op_count[i]) op_count[i] = 0;
      foreach (status_count[i]) status_count[i] = 0;
   endfunction

   // fold one accepted request word into the column statistics and queue its result
   function void note_request(logic [cmms_pkg::OP_W-1:0] op, logic [cmms_pkg::COL_W-1:0] col,
                              logic [cmms_pkg::DATA_W-1:0] smp,
                              logic [cmms_pkg::DATA_W-1:0] gmax);
      cmms_pkg::result_type res;
      longint               span;
      longint               num;
      longint               quo;
      res = '0;
      res.status = cmms_pkg::ST_OK;
      op_count[op]++;
      case (op)
         cmms_pkg::OP_CLEAR: begin
            foreach (col_seen[i]) col_seen[i] = 1'b0;
         end
         cmms_pkg::OP_TRACK: begin
            if (!col_seen[col]) begin
               col_low[col]  = smp;
               col_high[col] = smp;
               col_seen[col] = 1'b1;
            end else begin
               if ($signed(smp) < col_low[col]) col_low[col] = smp;
               if ($signed(smp) > col_high[col]) col_high[col] = smp;
            end
            res.cmin = col_low[col];
            res.cmax = col_high[col];
         end
         cmms_pkg::OP_LOAD: begin
            col_low[col]  = smp;
            col_high[col] = gmax;
            col_seen[col] = 1'b1;
            res.cmin = smp;
            res.cmax = gmax;
         end
         cmms_pkg::OP_SCALE, cmms_pkg::OP_READ: begin
            if (!col_seen[col]) begin
               res.status = cmms_pkg::ST_NO_STATS;
            end else begin
               res.cmin = col_low[col];
               res.cmax = col_high[col];
               if (op == cmms_pkg::OP_SCALE) begin
                  span = longint'(col_high[col]) - longint'(col_low[col]);
                  if (span == 0) begin
                     res.status = cmms_pkg::ST_ZERO_RANGE;
                  end else begin
                     num = (longint'($signed(smp)) - longint'(col_low[col]))
                           * (longint'(1) <<< cmms_pkg::FRAC_W);
                     quo = num / span;
                     if (quo > longint'($signed(cmms_pkg::SAT_MAX))) begin
                        quo = longint'($signed(cmms_pkg::SAT_MAX));
                        res.status = cmms_pkg::ST_SATURATED;
                     end else if (quo < longint'($signed(cmms_pkg::SAT_MIN))) begin
                        quo = longint'($signed(cmms_pkg::SAT_MIN));
                        res.status = cmms_pkg::ST_SATURATED;
                     end
                     res.scaled = quo[cmms_pkg::DATA_W-1:0];
                  end
               end
            end
         end
         default: begin
         end
      endcase
      awaited_results.push_back(res);
   endfunction

   function void compare_field(string name, logic [cmms_pkg::DATA_W-1:0] want,
                               logic [cmms_pkg::DATA_W-1:0] got);
      if (got !== want) begin
         errors++;
         reported++;
         if (reported <= REPORT_CAP)
            $display("%0t: word %0d %s expected %h actual %h",
                     $time, words_checked, name, want, got);
         else if (reported == REPORT_CAP + 1)
            $display("%0t: further mismatches not shown", $time);
      end
   endfunction

   function void check_response(logic [95:0] data, logic [1:0] user);
      cmms_pkg::result_type want;
      if (awaited_results.size() == 0) begin
         errors++;
         $display("%0t: result word with none expected, data %h status %h",
                  $time, data, user);
         return;
      end
      want = awaited_results.pop_front();
      status_count[want.status]++;
      compare_field("scaled", want.scaled, data[31:0]);
      compare_field("col_min_out", want.cmin, data[63:32]);
      compare_field("col_max_out", want.cmax, data[95:64]);
      compare_field("status", {30'd0, want.status}, {30'd0, user});
      words_checked++;
   endfunction
endclass

module column_min_max_scaler_test;
   import cmms_pkg::*;

   localparam int                IDLE_LIMIT     = 4000;  // cycles without any handshake
   localparam int                RANDOM_WORDS   = 1400;
   localparam int                SETTLE_CYCLES  = 60;    // longer than one scale
   localparam int                SMALL_SPAN     = 1 << 20;
   localparam logic [OP_W-1:0]   OP_SPARE_FIRST = 3'd5;  // unused operation codes
   localparam logic [OP_W-1:0]   OP_SPARE_LAST  = 3'd7;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;   // column[5:0], sample[37:6], given_max[69:38], zero
   logic [2:0]  req_tuser;   // operation[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [95:0] rsp_tdata;   // scaled[31:0], col_min_out[63:32], col_max_out[95:64]
   logic [1:0]  rsp_tuser;   // status[1:0]

   scaler_scoreboard sb = new();

   int burst_left     = 0;
   bit steady_sender  = 1'b0;   // no gaps between words while set
   int stall_left     = 0;
   int stall_mode     = 0;
   int idle_cycles    = 0;

   column_min_max_scaler u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result side: sampled at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata, rsp_tuser);
   end

   // receiver stalls: random switches between modes of no stalls, short frequent stalls and long rare ones
   initial begin
      int cycle_count;
      cycle_count = 0;
      rsp_tready  = 1'b0;
      forever begin
         @(negedge clock);
         cycle_count++;
         if (cycle_count % 300 == 0) stall_mode = $urandom_range(0, 2);
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = 1'b1;
            case (stall_mode)
               1: if ($urandom_range(0, 99) < 40) stall_left = $urandom_range(1, 3);
               2: if ($urandom_range(0, 99) < 5) stall_left = $urandom_range(10, 60);
               default: stall_left = 0;
            endcase
         end
      end
   end

   // watchdog: ends the run when neither channel has moved a word for too long
   initial begin
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // one request word; the sender works in bursts with random gaps in between
   task automatic send_word(input logic [OP_W-1:0] op, input logic [COL_W-1:0] col,
                            input logic [DATA_W-1:0] smp, input logic [DATA_W-1:0] gmax);
      int gap;
      if (burst_left == 0) begin
         gap = steady_sender ? 0 : $urandom_range(0, 12);
         repeat (gap) begin
            @(negedge clock);
            req_tvalid = 1'b0;
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {2'b00, gmax, smp, col};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_request(op, col, smp, gmax);
   endtask

   // hold the sender off until every queued result has come back
   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      burst_left = 0;
      while (sb.awaited_results.size() != 0) @(posedge clock);
   endtask

   // mostly small values so that scaled results stay in range, with some full-range
   // and extreme values mixed in
   function automatic logic [DATA_W-1:0] pick_value();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1: return $urandom;
         2: begin
            case ($urandom_range(0, 3))
               0: return SAT_MAX;
               1: return SAT_MIN;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return int'($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN;
      endcase
   endfunction

   task automatic random_word();
      int                 pick;
      logic [OP_W-1:0]    op;
      logic [COL_W-1:0]   col;
      logic [DATA_W-1:0]  smp;
      logic [DATA_W-1:0]  gmax;
      pick = $urandom_range(0, 99);
      // a few hot columns keep statistics alive between clears
      col  = ($urandom_range(0, 3) == 0) ? COL_W'($urandom_range(0, MAX_COLUMNS - 1))
                                         : COL_W'($urandom_range(0, 7));
      smp  = pick_value();
      gmax = $urandom;   // ignored unless loading
      if (pick < 35) begin
         op = OP_TRACK;
      end else if (pick < 65) begin
         op = OP_SCALE;
      end else if (pick < 77) begin
         op = OP_READ;
      end else if (pick < 90) begin
         op = OP_LOAD;
         case ($urandom_range(0, 9))
            0, 1: gmax = pick_value();                     // may sit below the minimum
            2:    gmax = smp;                              // zero range
            default: gmax = smp + $urandom_range(1, 1 << 22);
         endcase
      end else if (pick < 92) begin
         op = OP_CLEAR;
      end else if (pick < 95) begin
         op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      end else begin
         op  = OP_TRACK;
         col = COL_W'($urandom);
         smp = $urandom;
      end
      send_word(op, col, smp, gmax);
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // directed: columns without statistics
      send_word(OP_READ,  6'd0, 32'h0000_0000, 32'h0000_0000);
      send_word(OP_SCALE, 6'd0, 32'h0001_0000, 32'hFFFF_FFFF);
      // first sample then widening, over the whole value range
      send_word(OP_TRACK, 6'd0, SAT_MAX, 32'h0000_0000);
      send_word(OP_TRACK, 6'd0, SAT_MIN, 32'hFFFF_FFFF);
      send_word(OP_SCALE, 6'd0, SAT_MAX, 32'h0000_0000);
      send_word(OP_SCALE, 6'd0, SAT_MIN, 32'h0000_0000);
      send_word(OP_SCALE, 6'd0, 32'h0000_0000, 32'h0000_0000);
      // zero range after a single sample
      send_word(OP_TRACK, 6'd1, 32'h0005_8000, 32'h0000_0000);
      send_word(OP_SCALE, 6'd1, 32'h0005_8000, 32'h0000_0000);
      // tiny range saturates both ways
      send_word(OP_LOAD,  6'd2, 32'h0000_0000, 32'h0000_0001);
      send_word(OP_SCALE, 6'd2, SAT_MAX, 32'h0000_0000);
      send_word(OP_SCALE, 6'd2, SAT_MIN, 32'h0000_0000);
      // loaded minimum above maximum: negative range
      send_word(OP_LOAD,  6'd3, 32'h0001_0000, 32'h0000_0000);
      send_word(OP_SCALE, 6'd3, 32'h0000_0000, 32'h0000_0000);
      send_word(OP_SCALE, 6'd3, 32'h0000_8000, 32'h0000_0000);
      send_word(OP_READ,  6'd3, 32'h0000_0000, 32'h0000_0000);
      // last column, extreme loaded values
      send_word(OP_LOAD,  6'd63, SAT_MIN, SAT_MAX);
      send_word(OP_READ,  6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // unused operation codes
      send_word(OP_SPARE_FIRST, 6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(OP_SPARE_FIRST + 3'd1, 6'd63, 32'h1234_5678, 32'h8765_4321);
      send_word(OP_SPARE_LAST, 6'd2, 32'h0000_0000, 32'h0000_0000);
      // clear all drops every column
      send_word(OP_CLEAR, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(OP_READ,  6'd0, 32'h0000_0000, 32'h0000_0000);
      send_word(OP_SCALE, 6'd63, 32'h0000_0000, 32'h0000_0000);
      send_word(OP_TRACK, 6'd63, 32'hFFFF_0000, 32'h7FFF_0000);
      wait_for_results();

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i % 200 == 0) steady_sender = ($urandom_range(0, 2) == 0);
         if (i == RANDOM_WORDS / 2) wait_for_results();
         random_word();
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.awaited_results.size() != 0) begin
         sb.errors++;
         $display("%0t: %0d results never arrived", $time, sb.awaited_results.size());
      end

      $display("covered %0d words: %0d track, %0d scale, %0d load, %0d read, %0d clear,",
               sb.words_checked, sb.op_count[OP_TRACK], sb.op_count[OP_SCALE],
               sb.op_count[OP_LOAD], sb.op_count[OP_READ], sb.op_count[OP_CLEAR]);
      $display("%0d spare; statuses: %0d ok, %0d zero range, %0d saturated, %0d no statistics",
               sb.op_count[5] + sb.op_count[6] + sb.op_count[7],
               sb.status_count[ST_OK], sb.status_count[ST_ZERO_RANGE],
               sb.status_count[ST_SATURATED], sb.status_count[ST_NO_STATS]);
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
